/* rtl/srs_pkg.sv */
package srs_pkg;

	// One stored record: packed name, type character and signed value.
	typedef struct packed {
		logic        [63:0] name;
		logic        [7:0]  tag;
		logic signed [31:0] value;
	} rec_t;

	// Request codes carried in the kind field.
	typedef enum logic [2:0] {
		KIND_PUSH  = 3'd0,
		KIND_POP   = 3'd1,
		KIND_CLEAR = 3'd2,
		KIND_PEEK  = 3'd3,
		KIND_SORT  = 3'd4
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Sort sequencer states, one-hot.
	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_FIRST_RD = 9'b000000010,
		ST_FIRST_WR = 9'b000000100,
		ST_POP_RD   = 9'b000001000,
		ST_POP_CMP  = 9'b000010000,
		ST_MOVE     = 9'b000100000,
		ST_MOVE_CMP = 9'b001000000,
		ST_DRAIN_RD = 9'b010000000,
		ST_DRAIN_WR = 9'b100000000
	} sort_state_t;

endpackage

/* rtl/srs_if.sv */
// Request channel: one stack operation per transfer.
interface srs_req_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  kind;
	logic        [63:0] item_name;
	logic        [7:0]  item_tag;
	logic signed [31:0] item_value;

	modport source (output valid, kind, item_name, item_tag, item_value, input ready);
	modport sink (input valid, kind, item_name, item_tag, item_value, output ready);
endinterface

// Result channel: one result per request.
interface srs_rsp_if #(
	parameter int DEPTH_W = 9
);
	logic                valid;
	logic                ready;
	logic        [1:0]   status;
	logic        [63:0]  out_name;
	logic        [7:0]   out_tag;
	logic signed [31:0]  out_value;
	logic [DEPTH_W-1:0]  depth_now;

	modport source (output valid, status, out_name, out_tag, out_value, depth_now,
		input ready);
	modport sink (input valid, status, out_name, out_tag, out_value, depth_now,
		output ready);
endinterface

/* rtl/sortable_record_stack.sv */
// Bounded LIFO stack of records (8-byte name, type byte, signed 32-bit value).
// Requests arrive on the req channel and every request gives exactly one
// result on the rsp channel, in order. Push, pop, clear and peek are taken
// one per cycle unless a stalled result blocks them; each result passes stage
// one and then the output register, which holds it. Pop and peek read the top
// record from the main record memory, whose read port is registered. Sort
// rearranges the records with a second record memory used as the auxiliary
// stack. Its result is issued at once (the count does not change), but no
// further request is taken until the sort finishes: each record moved between
// the memories takes a read and a write state, so a sort is shortest when
// already in order and longest when the records are reversed.
// A push onto a full stack is dropped with a full status; pop, peek and sort
// on an empty stack report an empty status.
// Reset empties the stack at once; memory contents stay as they are and are
// never read before being written. When the receiver stalls, the output
// register and one pipeline stage fill and then req.ready falls.
module sortable_record_stack #(
	parameter int STACK_DEPTH = 256
) (
	input logic        clk,
	input logic        arst_n,
	srs_req_if.sink    req,
	srs_rsp_if.source  rsp
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int RW = $bits(srs_pkg::rec_t);
	localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);
	localparam logic [CW-1:0] TWO_CNT  = CW'(2);

	srs_pkg::sort_state_t state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d, cnt_m1;
	logic [CW-1:0]   side_q, side_d, side_m1, side_m2;
	srs_pkg::rec_t   x_q, x_d;
	srs_pkg::rec_t   top_q, top_d;
	srs_pkg::rec_t   req_rec;

	logic            m_we, m_re;
	logic [AW-1:0]   m_waddr, m_raddr;
	srs_pkg::rec_t   m_wdata, m_rdata;
	logic            s_we, s_re;
	logic [AW-1:0]   s_waddr, s_raddr;
	srs_pkg::rec_t   s_wdata, s_rdata;

	logic              in_fire, advance;
	srs_pkg::status_t  acc_status;
	logic              acc_rd;
	srs_pkg::rec_t     place_rec;

	logic              v_s1, rd_s1;
	srs_pkg::status_t  status_s1;
	logic [CW-1:0]     depth_s1;

	logic              out_v_q;
	srs_pkg::status_t  status_q;
	srs_pkg::rec_t     out_rec_q;
	logic [CW-1:0]     depth_q;

	assign in_fire = req.valid && req.ready;
	assign advance = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = (state_q == srs_pkg::ST_IDLE) && (!v_s1 || advance);

	assign req_rec.name  = req.item_name;
	assign req_rec.tag   = req.item_tag;
	assign req_rec.value = req.item_value;

	assign cnt_m1  = cnt_q - ONE_CNT;
	assign side_m1 = side_q - ONE_CNT;
	assign side_m2 = side_q - TWO_CNT;

	// Record memories: the stack itself and the auxiliary stack for sorting.
	srs_ram #(.WIDTH(RW), .DEPTH(STACK_DEPTH)) u_main_ram (
		.clk     (clk),
		.wr_en   (m_we),
		.wr_addr (m_waddr),
		.wr_data (m_wdata),
		.rd_en   (m_re),
		.rd_addr (m_raddr),
		.rd_data (m_rdata)
	);

	srs_ram #(.WIDTH(RW), .DEPTH(STACK_DEPTH)) u_side_ram (
		.clk     (clk),
		.wr_en   (s_we),
		.wr_addr (s_waddr),
		.wr_data (s_wdata),
		.rd_en   (s_re),
		.rd_addr (s_raddr),
		.rd_data (s_rdata)
	);

	// Request handling and the sort sequencer share the memory ports.
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		side_d     = side_q;
		x_d        = x_q;
		top_d      = top_q;
		m_we       = 1'b0;
		m_waddr    = cnt_q[AW-1:0];
		m_wdata    = top_q;
		m_re       = 1'b0;
		m_raddr    = cnt_m1[AW-1:0];
		s_we       = 1'b0;
		s_waddr    = side_q[AW-1:0];
		s_wdata    = x_q;
		s_re       = 1'b0;
		s_raddr    = side_m2[AW-1:0];
		acc_status = srs_pkg::STATUS_OK;
		acc_rd     = 1'b0;
		place_rec  = x_q;

		case (state_q)
			srs_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (srs_pkg::kind_t'(req.kind))
						srs_pkg::KIND_PUSH: begin
							if (cnt_q == FULL_CNT) begin
								acc_status = srs_pkg::STATUS_FULL;
							end else begin
								m_we    = 1'b1;
								m_wdata = req_rec;
								cnt_d   = cnt_q + ONE_CNT;
							end
						end
						srs_pkg::KIND_POP, srs_pkg::KIND_PEEK: begin
							if (cnt_q == '0) begin
								acc_status = srs_pkg::STATUS_EMPTY;
							end else begin
								m_re   = 1'b1;
								acc_rd = 1'b1;
								if (req.kind == srs_pkg::KIND_POP) begin
									cnt_d = cnt_m1;
								end
							end
						end
						srs_pkg::KIND_CLEAR: begin
							cnt_d = '0;
						end
						srs_pkg::KIND_SORT: begin
							if (cnt_q == '0) begin
								acc_status = srs_pkg::STATUS_EMPTY;
							end else begin
								state_d = srs_pkg::ST_FIRST_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			// Move the first record straight onto the auxiliary stack.
			srs_pkg::ST_FIRST_RD: begin
				m_re    = 1'b1;
				cnt_d   = cnt_m1;
				state_d = srs_pkg::ST_FIRST_WR;
			end
			srs_pkg::ST_FIRST_WR: begin
				s_we    = 1'b1;
				s_wdata = m_rdata;
				top_d   = m_rdata;
				side_d  = ONE_CNT;
				state_d = (cnt_q == '0) ? srs_pkg::ST_DRAIN_RD : srs_pkg::ST_POP_RD;
			end
			// Take the next record off the main stack and compare it with the
			// auxiliary top.
			srs_pkg::ST_POP_RD: begin
				m_re    = 1'b1;
				cnt_d   = cnt_m1;
				state_d = srs_pkg::ST_POP_CMP;
			end
			srs_pkg::ST_POP_CMP: begin
				x_d = m_rdata;
				if ($signed(m_rdata.value) >= $signed(top_q.value)) begin
					s_we    = 1'b1;
					s_wdata = m_rdata;
					top_d   = m_rdata;
					side_d  = side_q + ONE_CNT;
					state_d = (cnt_q == '0) ? srs_pkg::ST_DRAIN_RD : srs_pkg::ST_POP_RD;
				end else begin
					state_d = srs_pkg::ST_MOVE;
				end
			end
			// Return the larger auxiliary top to the main stack and fetch the
			// record below it.
			srs_pkg::ST_MOVE: begin
				m_we    = 1'b1;
				m_wdata = top_q;
				cnt_d   = cnt_q + ONE_CNT;
				side_d  = side_m1;
				if (side_m1 != '0) begin
					s_re = 1'b1;
				end
				state_d = srs_pkg::ST_MOVE_CMP;
			end
			srs_pkg::ST_MOVE_CMP: begin
				if (side_q != '0 && $signed(x_q.value) < $signed(s_rdata.value)) begin
					top_d   = s_rdata;
					state_d = srs_pkg::ST_MOVE;
				end else begin
					s_we    = 1'b1;
					s_wdata = place_rec;
					top_d   = place_rec;
					side_d  = side_q + ONE_CNT;
					state_d = (cnt_q == '0) ? srs_pkg::ST_DRAIN_RD : srs_pkg::ST_POP_RD;
				end
			end
			// Pour the auxiliary stack back onto the main stack.
			srs_pkg::ST_DRAIN_RD: begin
				if (side_q == '0) begin
					state_d = srs_pkg::ST_IDLE;
				end else begin
					s_re    = 1'b1;
					s_raddr = side_m1[AW-1:0];
					side_d  = side_m1;
					state_d = srs_pkg::ST_DRAIN_WR;
				end
			end
			srs_pkg::ST_DRAIN_WR: begin
				m_we    = 1'b1;
				m_wdata = s_rdata;
				cnt_d   = cnt_q + ONE_CNT;
				state_d = srs_pkg::ST_DRAIN_RD;
			end
			default: begin
				state_d = srs_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srs_pkg::ST_IDLE;
			cnt_q   <= '0;
			side_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			side_q  <= side_d;
		end
	end

	// Sort working records.
	always_ff @(posedge clk) begin
		x_q   <= x_d;
		top_q <= top_d;
	end

	// Stage one waits for the memory read of pop and peek.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_s1 <= acc_status;
			rd_s1     <= acc_rd;
			depth_s1  <= cnt_d;
		end
	end

	// Output register; it frees as soon as its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q  <= status_s1;
			out_rec_q <= rd_s1 ? m_rdata : '0;
			depth_q   <= depth_s1;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.status    = status_q;
	assign rsp.out_name  = out_rec_q.name;
	assign rsp.out_tag   = out_rec_q.tag;
	assign rsp.out_value = out_rec_q.value;
	assign rsp.depth_now = depth_q;

`ifndef SYNTH
	// The two stacks together never hold more records than the memory depth.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cnt_q) + 32'(side_q)) <= STACK_DEPTH)
		else $error("record count exceeds stack depth");

	// The auxiliary stack is empty whenever requests are taken.
	a_side_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srs_pkg::ST_IDLE) |-> (side_q == '0))
		else $error("auxiliary stack not empty while idle");

	// A sort leaves the record count as it found it.
	a_sort_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && state_d == srs_pkg::ST_FIRST_RD) |=> (depth_s1 == $past(cnt_q)))
		else $error("sort result reports a changed count");

	// A stalled result blocks new requests once stage one is full.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_v_q && !rsp.ready) |-> !req.ready)
		else $error("request taken while results are stalled");
`endif

endmodule

/* rtl/srs_ram.sv */
module srs_ram #(
	parameter int WIDTH = 104,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sim/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH = 256;
	localparam int DEPTH_W = 9;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int SETTLE_CYCLES = 16;
	// Random traffic stops pushing above this depth so that sorts stay short.
	localparam int SOFT_DEPTH_CAP = 48;

	// Request codes that the block does not define and must ignore.
	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_MID = 3'd6;
	localparam logic [2:0] KIND_SPARE_LAST = 3'd7;

	localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

	// One predicted result of the stack.
	typedef struct packed {
		srs_pkg::status_t       status;
		logic        [63:0]     name;
		logic        [7:0]      tag;
		logic signed [31:0]     value;
		logic [DEPTH_W-1:0]     depth;
	} stack_reply_t;

	logic clk;
	logic arst_n;

	srs_req_if req_ch ();
	srs_rsp_if #(.DEPTH_W(DEPTH_W)) rsp_ch ();

	sortable_record_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Predicted contents of the stack; entry 0 is the bottom.
	srs_pkg::rec_t held_records[STACK_DEPTH];
	srs_pkg::rec_t sort_spare[STACK_DEPTH];
	int unsigned held_count;

	stack_reply_t expected_replies[$];
	int fail_count;
	int cycle_count;
	int tx_idle_pct;
	int rx_idle_pct;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Guard against a hung block.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Reorder the predicted stack with the auxiliary-stack insertion method.
	// The smallest value ends on top and equal values keep their order.
	function automatic void sort_by_value();
		int unsigned spare_count;
		srs_pkg::rec_t cur;
		spare_count = 0;
		held_count = held_count - 1;
		sort_spare[spare_count] = held_records[held_count];
		spare_count = spare_count + 1;
		while (held_count > 0) begin
			held_count = held_count - 1;
			cur = held_records[held_count];
			while (spare_count > 0 &&
				$signed(cur.value) < $signed(sort_spare[spare_count - 1].value)) begin
				spare_count = spare_count - 1;
				held_records[held_count] = sort_spare[spare_count];
				held_count = held_count + 1;
			end
			sort_spare[spare_count] = cur;
			spare_count = spare_count + 1;
		end
		while (spare_count > 0) begin
			spare_count = spare_count - 1;
			held_records[held_count] = sort_spare[spare_count];
			held_count = held_count + 1;
		end
	endfunction

	// Apply one request to the predicted stack and return its result.
	function automatic stack_reply_t stack_apply(input logic [2:0] kind,
		input logic [63:0] name, input logic [7:0] tag, input logic signed [31:0] value);
		stack_reply_t r;
		r = '0;
		r.status = srs_pkg::STATUS_OK;
		case (kind)
			srs_pkg::KIND_PUSH: begin
				if (held_count >= STACK_DEPTH) begin
					r.status = srs_pkg::STATUS_FULL;
				end else begin
					held_records[held_count] = '{name: name, tag: tag, value: value};
					held_count = held_count + 1;
				end
			end
			srs_pkg::KIND_POP, srs_pkg::KIND_PEEK: begin
				if (held_count == 0) begin
					r.status = srs_pkg::STATUS_EMPTY;
				end else begin
					r.name = held_records[held_count - 1].name;
					r.tag = held_records[held_count - 1].tag;
					r.value = held_records[held_count - 1].value;
					if (kind == srs_pkg::KIND_POP)
						held_count = held_count - 1;
				end
			end
			srs_pkg::KIND_CLEAR: begin
				held_count = 0;
			end
			srs_pkg::KIND_SORT: begin
				if (held_count == 0)
					r.status = srs_pkg::STATUS_EMPTY;
				else
					sort_by_value();
			end
			default: begin
			end
		endcase
		r.depth = held_count[DEPTH_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
		input logic [63:0] want);
		$display("tb: mismatch on %s at %0t: got %h, expected %h",
			field, $realtime, got, want);
		fail_count = fail_count + 1;
	endtask

	// Receiver: stall at random according to the current idle rate.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Compare every result transfer with the oldest prediction.
	always @(posedge clk) begin : check_replies
		stack_reply_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("result with nothing expected", rsp_ch.out_name, '0);
			end else begin
				want = expected_replies.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
				if (rsp_ch.out_name !== want.name)
					report_mismatch("out_name", rsp_ch.out_name, want.name);
				if (rsp_ch.out_tag !== want.tag)
					report_mismatch("out_tag", 64'(rsp_ch.out_tag), 64'(want.tag));
				if (rsp_ch.out_value !== want.value)
					report_mismatch("out_value", 64'(rsp_ch.out_value), 64'(want.value));
				if (rsp_ch.depth_now !== want.depth)
					report_mismatch("depth_now", 64'(rsp_ch.depth_now), 64'(want.depth));
			end
		end
	end

	// Send one request and record its predicted result once the transfer happens.
	// Valid is only lowered when the sender actually idles, so it is never
	// lowered and raised within one time step.
	task automatic send_request(input logic [2:0] kind, input logic [63:0] name,
		input logic [7:0] tag, input logic signed [31:0] value);
		bit lowered;
		lowered = 1'b0;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			if (!lowered) begin
				req_ch.valid <= 1'b0;
				lowered = 1'b1;
			end
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.item_name <= name;
		req_ch.item_tag <= tag;
		req_ch.item_value <= value;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		expected_replies.push_back(stack_apply(kind, name, tag, value));
	endtask

	// Hold off the sender until every predicted result has arrived.
	task automatic drain_replies();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_replies.size() != 0);
	endtask

	function automatic logic [63:0] random_name();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [7:0] random_tag();
		return 8'($urandom_range(0, 255));
	endfunction

	// Half of the values come from a narrow band so that sorts see many ties.
	function automatic logic signed [31:0] random_value();
		if ($urandom_range(0, 1) == 0)
			return $urandom();
		return $signed($urandom_range(0, 7)) - 4;
	endfunction

	task automatic push_random();
		send_request(srs_pkg::KIND_PUSH, random_name(), random_tag(), random_value());
	endtask

	task automatic send_bare(input logic [2:0] kind);
		send_request(kind, random_name(), random_tag(), $urandom());
	endtask

	// Requests against an empty stack, and codes the block must ignore.
	task automatic test_empty_stack();
		send_bare(srs_pkg::KIND_POP);
		send_bare(srs_pkg::KIND_PEEK);
		send_bare(srs_pkg::KIND_SORT);
		send_bare(srs_pkg::KIND_CLEAR);
		send_bare(KIND_SPARE_FIRST);
		send_bare(KIND_SPARE_LAST);
	endtask

	// Field extremes, a stable sort over equal keys and a one-entry sort.
	task automatic test_basic_records();
		send_request(srs_pkg::KIND_PUSH, '0, 8'h00, VALUE_MAX);
		send_request(srs_pkg::KIND_PUSH, '1, 8'hff, VALUE_MIN);
		send_request(srs_pkg::KIND_PUSH, random_name(), random_tag(), 32'sd0);
		send_request(srs_pkg::KIND_PUSH, random_name(), random_tag(), -32'sd1);
		send_request(srs_pkg::KIND_PUSH, random_name(), random_tag(), VALUE_MAX);
		send_bare(srs_pkg::KIND_PEEK);
		send_bare(srs_pkg::KIND_SORT);
		send_bare(KIND_SPARE_MID);
		send_bare(srs_pkg::KIND_POP);
		send_bare(srs_pkg::KIND_POP);
		send_bare(srs_pkg::KIND_CLEAR);
		send_bare(srs_pkg::KIND_PEEK);
		push_random();
		send_bare(srs_pkg::KIND_SORT);
		send_bare(srs_pkg::KIND_POP);
	endtask

	// Fill the stack to its limit, overflow it, then sort the full stack.
	task automatic test_fill_to_limit();
		send_bare(srs_pkg::KIND_CLEAR);
		while (held_count < STACK_DEPTH)
			push_random();
		push_random();
		push_random();
		send_bare(srs_pkg::KIND_PEEK);
		send_bare(srs_pkg::KIND_SORT);
		send_bare(srs_pkg::KIND_POP);
		send_bare(srs_pkg::KIND_POP);
		send_bare(srs_pkg::KIND_PEEK);
		push_random();
		push_random();
		push_random();
		send_bare(srs_pkg::KIND_CLEAR);
	endtask

	// Weighted random mix; pushes stop above a soft depth cap.
	task automatic test_random_traffic(input int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (held_count > SOFT_DEPTH_CAP && pick < 45)
				pick = pick + 45;
			if (pick < 45)
				push_random();
			else if (pick < 72)
				send_bare(srs_pkg::KIND_POP);
			else if (pick < 82)
				send_bare(srs_pkg::KIND_PEEK);
			else if (pick < 89)
				send_bare(srs_pkg::KIND_SORT);
			else if (pick < 92)
				send_bare(srs_pkg::KIND_CLEAR);
			else if (pick < 95)
				send_bare(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)));
			else
				send_bare(srs_pkg::KIND_POP);
		end
	endtask

	// Reset, the test sequence and the final verdict.
	initial begin
		fail_count = 0;
		held_count = 0;
		tx_idle_pct = 27;
		rx_idle_pct = 54;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= srs_pkg::KIND_PUSH;
		req_ch.item_name <= '0;
		req_ch.item_tag <= '0;
		req_ch.item_value <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_stack();
		test_basic_records();
		test_random_traffic(380);

		tx_idle_pct = 54;
		rx_idle_pct = 27;
		drain_replies();
		test_fill_to_limit();
		test_random_traffic(380);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_traffic(200);
		drain_replies();
		test_random_traffic(200);

		// Let the last results arrive, then watch for stray ones.
		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_replies.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
